// ===== sv/ie2p_pkg.sv =====
// Shared types and constants for the input event to PS/2 byte converter.
// Holds the item structs, the front-to-back command record and the usage ROM.
// No dependencies.
package ie2p_pkg;

    // event kinds, also used as the byte source tag
    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_MOUSE = 2'd1;
    localparam logic [1:0] KIND_TIMER = 2'd2;

    // single-modifier codes and their set-1 scancodes
    localparam logic [7:0] MOD_LCTRL  = 8'b0000_0001;
    localparam logic [7:0] MOD_LSHIFT = 8'b0000_0010;
    localparam logic [7:0] MOD_LALT   = 8'b0000_0100;
    localparam logic [7:0] MOD_RSHIFT = 8'b0010_0000;
    localparam logic [7:0] SC_LCTRL   = 8'h1d;
    localparam logic [7:0] SC_LSHIFT  = 8'h2a;
    localparam logic [7:0] SC_LALT    = 8'h38;
    localparam logic [7:0] SC_RSHIFT  = 8'h36;
    localparam logic [7:0] SC_BREAK   = 8'h80;
    localparam logic [7:0] SC_MASK    = 8'h7f;

    localparam logic [1:0] BTN_NONE   = 2'd3;

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         key_usage;
        logic [7:0]         key_modifier;
        logic               key_press;
        logic signed [15:0] pointer_x;
        logic signed [15:0] pointer_y;
        logic               pointer_reset;
        logic               button_changed;
        logic [1:0]         button_index;
        logic               button_pressed;
    } t_in_item;

    typedef struct packed {
        logic [1:0] source;
        logic [7:0] data_byte;
        logic       last;
    } t_out_item;

    // one event's run of bytes; count is 1 to 3
    typedef struct packed {
        logic [1:0]      source;
        logic [1:0]      count;
        logic [7:0]      byte0;
        logic [7:0]      byte1;
        logic [7:0]      byte2;
    } t_cmd;

    // head of the command queue as seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    function automatic logic [7:0] usage_to_scancode(input logic [7:0] usage);
        logic [7:0] sc;
        unique case (usage)
            8'd4:  sc = 8'd30;  8'd5:  sc = 8'd48;  8'd6:  sc = 8'd46;  8'd7:  sc = 8'd32;
            8'd8:  sc = 8'd18;  8'd9:  sc = 8'd33;  8'd10: sc = 8'd34;  8'd11: sc = 8'd35;
            8'd12: sc = 8'd23;  8'd13: sc = 8'd36;  8'd14: sc = 8'd37;  8'd15: sc = 8'd38;
            8'd16: sc = 8'd50;  8'd17: sc = 8'd49;  8'd18: sc = 8'd24;  8'd19: sc = 8'd25;
            8'd20: sc = 8'd16;  8'd21: sc = 8'd19;  8'd22: sc = 8'd31;  8'd23: sc = 8'd20;
            8'd24: sc = 8'd22;  8'd25: sc = 8'd47;  8'd26: sc = 8'd17;  8'd27: sc = 8'd45;
            8'd28: sc = 8'd21;  8'd29: sc = 8'd44;  8'd30: sc = 8'd2;   8'd31: sc = 8'd3;
            8'd32: sc = 8'd4;   8'd33: sc = 8'd5;   8'd34: sc = 8'd6;   8'd35: sc = 8'd7;
            8'd36: sc = 8'd8;   8'd37: sc = 8'd9;   8'd38: sc = 8'd10;  8'd39: sc = 8'd11;
            8'd40: sc = 8'd28;  8'd42: sc = 8'd14;  8'd43: sc = 8'd15;  8'd44: sc = 8'd57;
            8'd45: sc = 8'd12;  8'd46: sc = 8'd13;  8'd47: sc = 8'd26;  8'd48: sc = 8'd27;
            8'd49: sc = 8'd43;  8'd51: sc = 8'd39;  8'd52: sc = 8'd40;  8'd53: sc = 8'd41;
            8'd54: sc = 8'd52;  8'd55: sc = 8'd53;  8'd56: sc = 8'd54;  8'd59: sc = 8'd59;
            8'd60: sc = 8'd60;  8'd64: sc = 8'd72;  8'd65: sc = 8'd73;  8'd66: sc = 8'd76;
            8'd67: sc = 8'd77;  8'd68: sc = 8'd78;  8'd70: sc = 8'd71;  8'd71: sc = 8'd72;
            8'd72: sc = 8'd81;  8'd73: sc = 8'd82;  8'd89: sc = 8'd74;  8'd90: sc = 8'd75;
            8'd91: sc = 8'd76;  8'd92: sc = 8'd70;  8'd93: sc = 8'd71;  8'd94: sc = 8'd74;
            8'd95: sc = 8'd64;  8'd96: sc = 8'd65;  8'd97: sc = 8'd66;  8'd98: sc = 8'd79;
            8'd99: sc = 8'd80;
            default: sc = 8'd0;
        endcase
        return sc;
    endfunction

endpackage

// ===== sv/ie2p_front.sv =====
// Front end: accepts events, keeps pointer and button state, builds byte runs.
// Depends on ie2p_pkg.
module ie2p_front
    import ie2p_pkg::*;
#(
    parameter int POS_WIDTH = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_push,
    output t_cmd     o_cmd
);

    localparam int EXT_W = (POS_WIDTH > 16) ? POS_WIDTH : 16;

    logic [POS_WIDTH-1:0] r_prev_x, n_prev_x;
    logic [POS_WIDTH-1:0] r_prev_y, n_prev_y;
    logic [2:0]           r_buttons, n_buttons;

    logic signed [EXT_W-1:0] ext_x, ext_y;
    logic [POS_WIDTH-1:0]    pos_x, pos_y;
    logic [POS_WIDTH:0]      dx, dy;
    logic [2:0]              btn_upd;
    logic [7:0]              mod_sc, key_sc;
    logic                    has_mod;
    logic                    emit;

    // wrap the 16-bit inputs to the position width
    assign ext_x = EXT_W'(i_item.pointer_x);
    assign ext_y = EXT_W'(i_item.pointer_y);
    assign pos_x = ext_x[POS_WIDTH-1:0];
    assign pos_y = ext_y[POS_WIDTH-1:0];

    // one extra bit keeps the true sign of the difference
    assign dx = {pos_x[POS_WIDTH-1], pos_x} - {r_prev_x[POS_WIDTH-1], r_prev_x};
    assign dy = {r_prev_y[POS_WIDTH-1], r_prev_y} - {pos_y[POS_WIDTH-1], pos_y};

    always_comb begin
        btn_upd = r_buttons;
        if (i_item.button_changed && i_item.button_index != BTN_NONE) begin
            btn_upd[i_item.button_index] = i_item.button_pressed;
        end
    end

    always_comb begin
        unique case (i_item.key_modifier)
            MOD_LCTRL:  mod_sc = SC_LCTRL;
            MOD_LSHIFT: mod_sc = SC_LSHIFT;
            MOD_LALT:   mod_sc = SC_LALT;
            MOD_RSHIFT: mod_sc = SC_RSHIFT;
            default:    mod_sc = 8'd0;
        endcase
        has_mod = (mod_sc != 8'd0);
        key_sc  = usage_to_scancode(i_item.key_usage);
        if (!i_item.key_press) begin
            mod_sc = mod_sc | SC_BREAK;
            key_sc = key_sc | SC_BREAK;
        end
    end

    always_comb begin
        emit      = 1'b0;
        o_cmd     = '0;
        n_prev_x  = r_prev_x;
        n_prev_y  = r_prev_y;
        n_buttons = r_buttons;
        o_cmd.source = i_item.kind;
        unique case (i_item.kind)
            KIND_KEY: begin
                emit        = 1'b1;
                o_cmd.count = has_mod ? 2'd2 : 2'd1;
                o_cmd.byte0 = has_mod ? mod_sc : key_sc;
                o_cmd.byte1 = key_sc;
            end
            KIND_MOUSE: begin
                if (i_item.pointer_reset) begin
                    n_buttons = 3'd0;
                end else begin
                    emit        = 1'b1;
                    n_prev_x    = pos_x;
                    n_prev_y    = pos_y;
                    n_buttons   = btn_upd;
                    o_cmd.count = 2'd3;
                    o_cmd.byte0 = {2'b00, dy[POS_WIDTH], dx[POS_WIDTH], 1'b1, btn_upd};
                    o_cmd.byte1 = dx[7:0];
                    o_cmd.byte2 = dy[7:0];
                end
            end
            KIND_TIMER: begin
                emit        = 1'b1;
                o_cmd.count = 2'd1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    assign o_push = i_accept && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_buttons <= '0;
        end else if (i_accept) begin
            r_prev_x  <= n_prev_x;
            r_prev_y  <= n_prev_y;
            r_buttons <= n_buttons;
        end
    end

endmodule

// ===== sv/ie2p_queue.sv =====
// Two-entry command queue between the front and back ends.
// Depends on ie2p_pkg.
module ie2p_queue
    import ie2p_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output logic    o_full,
    output t_q_head o_head
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count, n_count;

    assign o_full        = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_head.valid  = (r_count != '0);
    assign o_head.cmd    = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

// ===== sv/ie2p_back.sv =====
// Back end: walks the head command byte by byte into the output register.
// Depends on ie2p_pkg.
module ie2p_back
    import ie2p_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_head   i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic [1:0] r_idx;
    logic       r_out_valid;
    t_out_item  r_out;
    logic       load;
    logic       last_byte;
    logic [7:0] sel_byte;

    assign load      = i_head.valid && (!r_out_valid || !i_out_stall);
    assign last_byte = (r_idx == i_head.cmd.count - 2'd1);
    assign o_pop     = load && last_byte;

    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = i_head.cmd.byte0;
            2'd1:    sel_byte = i_head.cmd.byte1;
            default: sel_byte = i_head.cmd.byte2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.source    <= i_head.cmd.source;
            r_out.data_byte <= sel_byte;
            r_out.last      <= last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= last_byte ? 2'd0 : r_idx + 2'd1;
            end else if (!i_out_stall) begin
                // drop the taken byte
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== sv/input_event_to_ps2_bytes_unit.sv =====
// Top level of the input event to PS/2 byte converter.
// Depends on ie2p_pkg, ie2p_front, ie2p_queue and ie2p_back.

// Converts keyboard, mouse and timer events into PS/2 set-1 scancodes and
// three-byte mouse packets, one byte per output item with a last flag closing
// each event's run. Each event's bytes leave the output register one per
// cycle while the output is not stalled: a keyboard event sends one byte, or
// two when a single modifier byte leads, a mouse event three, a timer tick
// one. The one-byte output register in the back end sets that rate; a
// two-entry command queue lets new events enter while earlier bytes are still
// going out. A mouse reset, or an unknown kind, is taken and sends nothing.
// POS_WIDTH (9 to 32) sets the width of the stored pointer position.
module input_event_to_ps2_bytes_unit
    import ie2p_pkg::*;
#(
    parameter int POS_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic    in_accept;
    logic    q_push;
    logic    q_pop;
    logic    q_full;
    t_cmd    q_cmd;
    t_q_head q_head;

    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = q_full;

    ie2p_front #(
        .POS_WIDTH(POS_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(in_accept),
        .i_item  (i_in_item),
        .o_push  (q_push),
        .o_cmd   (q_cmd)
    );

    ie2p_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (q_cmd),
        .i_pop  (q_pop),
        .o_full (q_full),
        .o_head (q_head)
    );

    ie2p_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .o_pop      (q_pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_head.valid)
        else $error("queue popped while empty");

    a_timer_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.source == KIND_TIMER)
            |-> (o_out_item.last && o_out_item.data_byte == 8'd0))
        else $error("timer run is not a single zero byte");

    a_key_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.source == KIND_KEY && !o_out_item.last)
            |-> ((o_out_item.data_byte & SC_MASK) == SC_LCTRL
                 || (o_out_item.data_byte & SC_MASK) == SC_LSHIFT
                 || (o_out_item.data_byte & SC_MASK) == SC_LALT
                 || (o_out_item.data_byte & SC_MASK) == SC_RSHIFT))
        else $error("leading keyboard byte is not a modifier scancode");

    a_queue_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_full && !q_pop) |=> q_full)
        else $error("queue lost an entry without a pop");

endmodule
